// File: rtl/core/lbrr_pkg.sv
// ----------------------------------------------------------------------------
// lbrr_pkg
// Shared constants, codes and helpers of the bilinear RGB remap unit.
// ----------------------------------------------------------------------------
package lbrr_pkg;

   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 512;
   localparam int FRACTION_BITS  = 8;

   localparam int COORD_BITS     = 20;
   localparam int DIM_BITS       = 10;
   localparam int ADDR_BITS      = 18;
   localparam int CHAN_BITS      = 8;
   localparam int PIXEL_BITS     = 3 * CHAN_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam int STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int BANK_DEPTH     = (STORE_DEPTH + 1) / 2;
   localparam int BANK_BITS      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int LIN_MIN        = 2 * DIM_BITS + 1;
   localparam int LIN_BITS       = (LIN_MIN > BANK_BITS + 2) ? LIN_MIN : BANK_BITS + 2;
   localparam int POS_BITS       = DIM_BITS + FRACTION_BITS;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 10'd512;

   // Clamp a register value into 1..max_dim.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value,
                                                     input int max_dim);
      logic [DIM_BITS-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_BITS'(1);
      end else if (32'(value) > max_dim) begin
         result = DIM_BITS'(max_dim);
      end
      return result;
   endfunction

endpackage

// File: rtl/core/lbrr_ram.sv
// ----------------------------------------------------------------------------
// lbrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbrr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lbrr_lerp.sv
// ----------------------------------------------------------------------------
// lbrr_lerp
// Two-stage bilinear blend of one color channel: horizontal, then vertical.
// ----------------------------------------------------------------------------
module lbrr_lerp
   import lbrr_pkg::*;
(
   input  logic                         clock,
   input  logic                         enable,
   input  logic [CHAN_BITS-1:0]         p00,
   input  logic [CHAN_BITS-1:0]         p10,
   input  logic [CHAN_BITS-1:0]         p01,
   input  logic [CHAN_BITS-1:0]         p11,
   input  logic [FRACTION_BITS-1:0]     fx,
   input  logic [FRACTION_BITS-1:0]     fy,
   output logic [CHAN_BITS+2*FRACTION_BITS-1:0] blend
);

   localparam int TOP_BITS = CHAN_BITS + FRACTION_BITS;
   localparam int VAL_BITS = CHAN_BITS + 2 * FRACTION_BITS;

   logic [TOP_BITS-1:0]      top_ff, top_in, bot_ff, bot_in;
   logic [FRACTION_BITS-1:0] fy_ff;
   logic [VAL_BITS-1:0]      val_ff, val_in;

   logic signed [CHAN_BITS:0]            diff_top, diff_bot;
   logic signed [CHAN_BITS+FRACTION_BITS+1:0] prod_top, prod_bot, sum_top, sum_bot;
   logic signed [TOP_BITS:0]             diff_val;
   logic signed [VAL_BITS+1:0]           prod_val, sum_val;

   // horizontal blend of both rows
   always_comb begin
      diff_top = $signed({1'b0, p10}) - $signed({1'b0, p00});
      diff_bot = $signed({1'b0, p11}) - $signed({1'b0, p01});
      prod_top = (CHAN_BITS+FRACTION_BITS+2)'(diff_top * $signed({1'b0, fx}));
      prod_bot = (CHAN_BITS+FRACTION_BITS+2)'(diff_bot * $signed({1'b0, fx}));
      sum_top  = $signed({2'b00, p00, {FRACTION_BITS{1'b0}}}) + prod_top;
      sum_bot  = $signed({2'b00, p01, {FRACTION_BITS{1'b0}}}) + prod_bot;
      top_in   = sum_top[TOP_BITS-1:0];
      bot_in   = sum_bot[TOP_BITS-1:0];
   end

   // vertical blend
   always_comb begin
      diff_val = $signed({1'b0, bot_ff}) - $signed({1'b0, top_ff});
      prod_val = (VAL_BITS+2)'(diff_val * $signed({1'b0, fy_ff}));
      sum_val  = $signed({2'b00, top_ff, {FRACTION_BITS{1'b0}}}) + prod_val;
      val_in   = sum_val[VAL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= fy;
         val_ff <= val_in;
      end
   end

   assign blend = val_ff;

endmodule

// File: rtl/core/lut_bilinear_rgb_remap_unit.sv
// ----------------------------------------------------------------------------
// lut_bilinear_rgb_remap_unit
// Bilinear remap of a stored RGB image driven by a coordinate LUT stream.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries two kinds of beats. A write beat (operation 0)
//   stores one source pixel at a linear address y*width+x and returns nothing.
//   A sample beat (operation 1) carries a signed fixed-point coordinate and
//   returns exactly one rsp_ beat with the interpolated RGB value and a copy
//   of its frame-end mark. Beats leave in the order they came in.
//   The csr_ channel sets source width and height; it is always ready and
//   should only be written while the pipeline is empty.
//   Throughput is one beat per clock while no result is stalled. A sample
//   raises rsp_valid after passing eight register stages: input register
//   (loaded at the accepting edge), clamp, row multiply, address add, RAM
//   read, horizontal blend, vertical blend, output register.
//   The image lives twice (one copy for each of the two rows touched), each
//   copy split into even and odd linear addresses, so the four neighbors come
//   out of four RAM read ports in the same cycle.
//   Reset clears the pipeline valids and restores a 512 x 512 image size; the
//   image RAM is not cleared and holds garbage until written.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module lut_bilinear_rgb_remap_unit
   import lbrr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [ADDR_BITS-1:0]          req_pixel_address,
   input  logic [CHAN_BITS-1:0]          req_write_red,
   input  logic [CHAN_BITS-1:0]          req_write_green,
   input  logic [CHAN_BITS-1:0]          req_write_blue,
   input  logic signed [COORD_BITS-1:0]  req_sample_u,
   input  logic signed [COORD_BITS-1:0]  req_sample_v,
   input  logic                          req_frame_end,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHAN_BITS-1:0]          rsp_red,
   output logic [CHAN_BITS-1:0]          rsp_green,
   output logic [CHAN_BITS-1:0]          rsp_blue,
   output logic                          rsp_last_of_frame,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [DIM_BITS-1:0]           csr_data
);

   localparam int VAL_BITS = CHAN_BITS + 2 * FRACTION_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers, held already clamped to 1..MAX
   // ---------------------------------------------------------------------
   logic [DIM_BITS-1:0] width_ff, width_in, height_ff, height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SOURCE_WIDTH:  width_in  = clamp_dim(csr_data, MAX_WIDTH);
            REG_SOURCE_HEIGHT: height_in = clamp_dim(csr_data, MAX_HEIGHT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(DIM_RESET, MAX_WIDTH);
         height_ff <= clamp_dim(DIM_RESET, MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Global pipeline advance: hold everything while a result is stalled
   // ---------------------------------------------------------------------
   logic advance;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------------
   logic                         s1_valid_ff;
   logic                         s1_op_ff;
   logic [ADDR_BITS-1:0]         s1_addr_ff;
   logic [PIXEL_BITS-1:0]        s1_pixel_ff;
   logic signed [COORD_BITS-1:0] s1_u_ff, s1_v_ff;
   logic                         s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= req_operation;
         s1_addr_ff  <= req_pixel_address;
         s1_pixel_ff <= {req_write_red, req_write_green, req_write_blue};
         s1_u_ff     <= req_sample_u;
         s1_v_ff     <= req_sample_v;
         s1_last_ff  <= req_frame_end;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: clamp the coordinate into the image, split integer/fraction
   // ---------------------------------------------------------------------
   logic [POS_BITS-1:0] u_clamped, v_clamped;
   logic [POS_BITS-1:0] u_hi, v_hi;
   logic signed [31:0]  u_ext, v_ext;

   always_comb begin
      u_hi  = POS_BITS'({width_ff - DIM_BITS'(1), {FRACTION_BITS{1'b0}}});
      v_hi  = POS_BITS'({height_ff - DIM_BITS'(1), {FRACTION_BITS{1'b0}}});
      u_ext = 32'(s1_u_ff);
      v_ext = 32'(s1_v_ff);
      if (u_ext < 0) begin
         u_clamped = '0;
      end else if (u_ext > $signed(32'(u_hi))) begin
         u_clamped = u_hi;
      end else begin
         u_clamped = u_ext[POS_BITS-1:0];
      end
      if (v_ext < 0) begin
         v_clamped = '0;
      end else if (v_ext > $signed(32'(v_hi))) begin
         v_clamped = v_hi;
      end else begin
         v_clamped = v_ext[POS_BITS-1:0];
      end
   end

   logic                     s2_valid_ff;
   logic                     s2_op_ff;
   logic [ADDR_BITS-1:0]     s2_addr_ff;
   logic [PIXEL_BITS-1:0]    s2_pixel_ff;
   logic [DIM_BITS-1:0]      s2_x0_ff, s2_y0_ff;
   logic [FRACTION_BITS-1:0] s2_fx_ff, s2_fy_ff;
   logic                     s2_xe_ff, s2_ye_ff;
   logic                     s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff    <= s1_op_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_pixel_ff <= s1_pixel_ff;
         s2_x0_ff    <= u_clamped[POS_BITS-1:FRACTION_BITS];
         s2_y0_ff    <= v_clamped[POS_BITS-1:FRACTION_BITS];
         s2_fx_ff    <= u_clamped[FRACTION_BITS-1:0];
         s2_fy_ff    <= v_clamped[FRACTION_BITS-1:0];
         s2_xe_ff    <= (u_clamped == u_hi);
         s2_ye_ff    <= (v_clamped == v_hi);
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: row start address y0 * width
   // ---------------------------------------------------------------------
   logic                     s3_valid_ff;
   logic                     s3_op_ff;
   logic [ADDR_BITS-1:0]     s3_addr_ff;
   logic [PIXEL_BITS-1:0]    s3_pixel_ff;
   logic [2*DIM_BITS-1:0]    s3_row_ff;
   logic [DIM_BITS-1:0]      s3_x0_ff;
   logic [FRACTION_BITS-1:0] s3_fx_ff, s3_fy_ff;
   logic                     s3_xe_ff, s3_ye_ff;
   logic                     s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_op_ff    <= s2_op_ff;
         s3_addr_ff  <= s2_addr_ff;
         s3_pixel_ff <= s2_pixel_ff;
         s3_row_ff   <= s2_y0_ff * width_ff;
         s3_x0_ff    <= s2_x0_ff;
         s3_fx_ff    <= s2_fx_ff;
         s3_fy_ff    <= s2_fy_ff;
         s3_xe_ff    <= s2_xe_ff;
         s3_ye_ff    <= s2_ye_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: linear addresses of the upper and lower left neighbors.
   // The right / lower neighbor is read at address + 1 / + width; at the
   // clamped edge that read's data is discarded and the left / upper pixel stands
   // in for it in stage 5.
   // ---------------------------------------------------------------------
   logic                     s4_valid_ff;
   logic                     s4_op_ff;
   logic [ADDR_BITS-1:0]     s4_addr_ff;
   logic [PIXEL_BITS-1:0]    s4_pixel_ff;
   logic [LIN_BITS-1:0]      s4_a0_ff, s4_a1_ff, a0_in;
   logic [FRACTION_BITS-1:0] s4_fx_ff, s4_fy_ff;
   logic                     s4_xe_ff, s4_ye_ff;
   logic                     s4_last_ff;

   assign a0_in = LIN_BITS'(s3_row_ff) + LIN_BITS'(s3_x0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_op_ff    <= s3_op_ff;
         s4_addr_ff  <= s3_addr_ff;
         s4_pixel_ff <= s3_pixel_ff;
         s4_a0_ff    <= a0_in;
         s4_a1_ff    <= a0_in + LIN_BITS'(width_ff);
         s4_fx_ff    <= s3_fx_ff;
         s4_fy_ff    <= s3_fy_ff;
         s4_xe_ff    <= s3_xe_ff;
         s4_ye_ff    <= s3_ye_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // RAM access: writes and reads both happen here to keep program order
   // ---------------------------------------------------------------------
   logic [LIN_BITS-1:0]   wr_lin, a0_inc, a1_inc;
   logic                  wr_hit, wr_even, wr_odd;
   logic [BANK_BITS-1:0]  wr_idx;
   logic [BANK_BITS-1:0]  r0_even_idx, r0_odd_idx, r1_even_idx, r1_odd_idx;
   logic [PIXEL_BITS-1:0] r0_even_q, r0_odd_q, r1_even_q, r1_odd_q;

   always_comb begin
      wr_lin  = LIN_BITS'(s4_addr_ff);
      wr_hit  = advance && s4_valid_ff && (s4_op_ff == OP_WRITE)
                && (32'(wr_lin) < STORE_DEPTH);
      wr_even = wr_hit && !wr_lin[0];
      wr_odd  = wr_hit && wr_lin[0];
      wr_idx  = wr_lin[BANK_BITS:1];
      a0_inc  = s4_a0_ff + LIN_BITS'(1);
      a1_inc  = s4_a1_ff + LIN_BITS'(1);
      // even bank holds the even one of {a, a+1}, odd bank the odd one
      r0_even_idx = a0_inc[BANK_BITS:1];
      r0_odd_idx  = s4_a0_ff[BANK_BITS:1];
      r1_even_idx = a1_inc[BANK_BITS:1];
      r1_odd_idx  = s4_a1_ff[BANK_BITS:1];
   end

   lbrr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(BANK_DEPTH)) u_row0_even (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (wr_idx),
      .wr_data (s4_pixel_ff),
      .rd_en   (advance),
      .rd_addr (r0_even_idx),
      .rd_data (r0_even_q)
   );

   lbrr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(BANK_DEPTH)) u_row0_odd (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (wr_idx),
      .wr_data (s4_pixel_ff),
      .rd_en   (advance),
      .rd_addr (r0_odd_idx),
      .rd_data (r0_odd_q)
   );

   lbrr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(BANK_DEPTH)) u_row1_even (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (wr_idx),
      .wr_data (s4_pixel_ff),
      .rd_en   (advance),
      .rd_addr (r1_even_idx),
      .rd_data (r1_even_q)
   );

   lbrr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(BANK_DEPTH)) u_row1_odd (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (wr_idx),
      .wr_data (s4_pixel_ff),
      .rd_en   (advance),
      .rd_addr (r1_odd_idx),
      .rd_data (r1_odd_q)
   );

   // ---------------------------------------------------------------------
   // Stage 5: RAM data out; steer banks back to left / right, then replace
   // the neighbors past the right or lower edge by the clamped pixels
   // ---------------------------------------------------------------------
   logic                     s5_valid_ff;
   logic                     s5_odd0_ff, s5_odd1_ff;
   logic                     s5_xe_ff, s5_ye_ff;
   logic [FRACTION_BITS-1:0] s5_fx_ff, s5_fy_ff;
   logic                     s5_last_ff;
   logic [PIXEL_BITS-1:0]    row0_left, row0_right, row1_left, row1_right;
   logic [PIXEL_BITS-1:0]    pix00, pix10, pix01, pix11;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff && (s4_op_ff == OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_odd0_ff <= s4_a0_ff[0];
         s5_odd1_ff <= s4_a1_ff[0];
         s5_xe_ff   <= s4_xe_ff;
         s5_ye_ff   <= s4_ye_ff;
         s5_fx_ff   <= s4_fx_ff;
         s5_fy_ff   <= s4_fy_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   always_comb begin
      row0_left  = s5_odd0_ff ? r0_odd_q  : r0_even_q;
      row0_right = s5_odd0_ff ? r0_even_q : r0_odd_q;
      row1_left  = s5_odd1_ff ? r1_odd_q  : r1_even_q;
      row1_right = s5_odd1_ff ? r1_even_q : r1_odd_q;
      pix00 = row0_left;
      pix10 = s5_xe_ff ? row0_left : row0_right;
      pix01 = s5_ye_ff ? pix00 : row1_left;
      pix11 = s5_ye_ff ? pix10 : (s5_xe_ff ? row1_left : row1_right);
   end

   // ---------------------------------------------------------------------
   // Stages 6 and 7: per-channel blend
   // ---------------------------------------------------------------------
   logic [VAL_BITS-1:0] blend [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      localparam int LSB = (2 - ch) * CHAN_BITS;
      lbrr_lerp u_lerp (
         .clock  (clock),
         .enable (advance),
         .p00    (pix00[LSB +: CHAN_BITS]),
         .p10    (pix10[LSB +: CHAN_BITS]),
         .p01    (pix01[LSB +: CHAN_BITS]),
         .p11    (pix11[LSB +: CHAN_BITS]),
         .fx     (s5_fx_ff),
         .fy     (s5_fy_ff),
         .blend  (blend[ch])
      );
   end

   logic s6_valid_ff, s6_last_ff, s7_valid_ff, s7_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_last_ff <= s5_last_ff;
         s7_last_ff <= s6_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8: round half up, saturate, output register
   // ---------------------------------------------------------------------
   logic [CHAN_BITS-1:0] chan_out [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic [VAL_BITS:0] rounded;
         rounded = {1'b0, blend[ch]} + (VAL_BITS+1)'(1 << (2*FRACTION_BITS - 1));
         if (rounded[VAL_BITS:2*FRACTION_BITS] > (VAL_BITS+1-2*FRACTION_BITS)'(255)) begin
            chan_out[ch] = '1;
         end else begin
            chan_out[ch] = rounded[2*FRACTION_BITS +: CHAN_BITS];
         end
      end
   end

   logic                 out_valid_ff, out_last_ff;
   logic [CHAN_BITS-1:0] out_red_ff, out_green_ff, out_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_red_ff   <= chan_out[0];
         out_green_ff <= chan_out[1];
         out_blue_ff  <= chan_out[2];
         out_last_ff  <= s7_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red           = out_red_ff;
   assign rsp_green         = out_green_ff;
   assign rsp_blue          = out_blue_ff;
   assign rsp_last_of_frame = out_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A coordinate clamped onto the last column or row carries no fraction.
   a_x_edge_zero_fx: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_x0_ff == width_ff - DIM_BITS'(1))) |-> (s2_fx_ff == '0))
      else $error("x edge sample with nonzero fraction");

   a_y_edge_zero_fy: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_y0_ff == height_ff - DIM_BITS'(1))) |-> (s2_fy_ff == '0))
      else $error("y edge sample with nonzero fraction");

   a_dims_in_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff != '0) && (height_ff != '0)
      && (32'(width_ff) <= MAX_WIDTH) && (32'(height_ff) <= MAX_HEIGHT))
      else $error("image size register out of range");

   a_no_rd_wr_mix: assert property (@(posedge clock) disable iff (reset)
      wr_hit |=> !s5_valid_ff)
      else $error("write beat turned into a result");

endmodule

// File: dv/tb_lut_bilinear_rgb_remap_unit.sv
// ----------------------------------------------------------------------------
// tb_lut_bilinear_rgb_remap_unit
// Self-checking bench for the bilinear RGB remap unit: loads source images of
// several sizes, streams samples across them and checks every result beat
// against a bit-exact fixed-point interpolator kept in the bench.
// ----------------------------------------------------------------------------
module tb_lut_bilinear_rgb_remap_unit;
   import lbrr_pkg::*;

   typedef struct {
      logic                         operation;
      logic [ADDR_BITS-1:0]         pixel_address;
      logic [CHAN_BITS-1:0]         wr_r;
      logic [CHAN_BITS-1:0]         wr_g;
      logic [CHAN_BITS-1:0]         wr_b;
      logic signed [COORD_BITS-1:0] u;
      logic signed [COORD_BITS-1:0] v;
      logic                         frame_end;
   } remap_req_type;

   typedef struct {
      logic [CHAN_BITS-1:0] r;
      logic [CHAN_BITS-1:0] g;
      logic [CHAN_BITS-1:0] b;
      logic                 last;
   } rgb_beat_type;

   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 150;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_operation;
   logic [ADDR_BITS-1:0]         req_pixel_address;
   logic [CHAN_BITS-1:0]         req_write_red;
   logic [CHAN_BITS-1:0]         req_write_green;
   logic [CHAN_BITS-1:0]         req_write_blue;
   logic signed [COORD_BITS-1:0] req_sample_u;
   logic signed [COORD_BITS-1:0] req_sample_v;
   logic                         req_frame_end;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [CHAN_BITS-1:0]         rsp_red;
   logic [CHAN_BITS-1:0]         rsp_green;
   logic [CHAN_BITS-1:0]         rsp_blue;
   logic                         rsp_last_of_frame;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [DIM_BITS-1:0]          csr_data;

   // bench-side copy of the image and the active geometry
   bit [PIXEL_BITS-1:0] image_copy [STORE_DEPTH];
   int                  img_w;
   int                  img_h;

   remap_req_type pending_beats[$];
   rgb_beat_type  rgb_expected[$];
   int         mismatches;
   bit         req_fire;
   bit         quiet;
   bit         long_hold_req;
   int         gap_left;
   int         stall_left;
   int         hold_left;
   int         idle_cycles;

   lut_bilinear_rgb_remap_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_pixel_address (req_pixel_address),
      .req_write_red     (req_write_red),
      .req_write_green   (req_write_green),
      .req_write_blue    (req_write_blue),
      .req_sample_u      (req_sample_u),
      .req_sample_v      (req_sample_v),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Register value as the block sees it: zero acts as one, large saturates.
   function automatic int dim_of(input logic [DIM_BITS-1:0] value, input int max_dim);
      if (value == '0) return 1;
      if (int'(value) > max_dim) return max_dim;
      return int'(value);
   endfunction

   // Blend one channel: horizontal on both rows, then vertical, round half up.
   function automatic logic [CHAN_BITS-1:0] blend_channel(input longint a, input longint b,
                                                          input longint d, input longint e,
                                                          input longint fx,
                                                          input longint fy);
      longint one;
      longint top;
      longint bot;
      longint val;
      longint rounded;
      one     = longint'(1) << FRACTION_BITS;
      top     = a * one + (b - a) * fx;
      bot     = d * one + (e - d) * fx;
      val     = top * one + (bot - top) * fy;
      rounded = (val + (longint'(1) << (2 * FRACTION_BITS - 1))) >>> (2 * FRACTION_BITS);
      if (rounded > 255) rounded = 255;
      return CHAN_BITS'(rounded);
   endfunction

   // Interpolated color at a fixed-point coordinate of the bench image.
   function automatic rgb_beat_type interpolate_rgb(input logic signed [COORD_BITS-1:0] u_raw,
                                                    input logic signed [COORD_BITS-1:0] v_raw,
                                                    input logic last);
      rgb_beat_type      beat;
      longint            u;
      longint            v;
      longint            x0;
      longint            y0;
      longint            x1;
      longint            y1;
      longint            fx;
      longint            fy;
      bit [PIXEL_BITS-1:0] p00;
      bit [PIXEL_BITS-1:0] p10;
      bit [PIXEL_BITS-1:0] p01;
      bit [PIXEL_BITS-1:0] p11;
      u = longint'(u_raw);
      v = longint'(v_raw);
      if (u < 0) u = 0;
      if (u > longint'(img_w - 1) << FRACTION_BITS) u = longint'(img_w - 1) << FRACTION_BITS;
      if (v < 0) v = 0;
      if (v > longint'(img_h - 1) << FRACTION_BITS) v = longint'(img_h - 1) << FRACTION_BITS;
      x0  = u >> FRACTION_BITS;
      y0  = v >> FRACTION_BITS;
      fx  = u & ((longint'(1) << FRACTION_BITS) - 1);
      fy  = v & ((longint'(1) << FRACTION_BITS) - 1);
      x1  = (x0 + 1 < img_w) ? x0 + 1 : img_w - 1;
      y1  = (y0 + 1 < img_h) ? y0 + 1 : img_h - 1;
      p00 = image_copy[y0 * img_w + x0];
      p10 = image_copy[y0 * img_w + x1];
      p01 = image_copy[y1 * img_w + x0];
      p11 = image_copy[y1 * img_w + x1];
      beat.r = blend_channel(p00[23:16], p10[23:16], p01[23:16], p11[23:16], fx, fy);
      beat.g = blend_channel(p00[15:8], p10[15:8], p01[15:8], p11[15:8], fx, fy);
      beat.b = blend_channel(p00[7:0], p10[7:0], p01[7:0], p11[7:0], fx, fy);
      beat.last = last;
      return beat;
   endfunction

   // Request side: feed beats from the pending queue, hold a beat until it is taken.
   always @(negedge clock) begin
      remap_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            item = pending_beats.pop_front();
            req_operation     <= item.operation;
            req_pixel_address <= item.pixel_address;
            req_write_red     <= item.wr_r;
            req_write_green   <= item.wr_g;
            req_write_blue    <= item.wr_b;
            req_sample_u      <= item.u;
            req_sample_v      <= item.v;
            req_frame_end     <= item.frame_end;
            req_valid         <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: short random stall bursts plus one long hold-off.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 4);
         rsp_stall <= (!quiet && stall_left > 0);
      end
   end

   // Sample both channels at the rising edge: predict on accept, check on result.
   always @(posedge clock) begin
      rgb_beat_type want;
      req_fire = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            req_fire    = 1'b1;
            idle_cycles = 0;
            if (req_operation == OP_WRITE) begin
               image_copy[req_pixel_address] = {req_write_red, req_write_green, req_write_blue};
            end else begin
               rgb_expected.push_back(interpolate_rgb(req_sample_u, req_sample_v,
                                                      req_frame_end));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (rgb_expected.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected: rgb %h %h %h last %b",
                        $time, rsp_red, rsp_green, rsp_blue, rsp_last_of_frame);
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_red !== want.r) begin
                  mismatches++;
                  $display("%0t: red exp %h got %h", $time, want.r, rsp_red);
               end
               if (rsp_green !== want.g) begin
                  mismatches++;
                  $display("%0t: green exp %h got %h", $time, want.g, rsp_green);
               end
               if (rsp_blue !== want.b) begin
                  mismatches++;
                  $display("%0t: blue exp %h got %h", $time, want.b, rsp_blue);
               end
               if (rsp_last_of_frame !== want.last) begin
                  mismatches++;
                  $display("%0t: last_of_frame exp %b got %b", $time, want.last,
                           rsp_last_of_frame);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("lut_bilinear_rgb_remap_unit regression: fail");
            $finish;
         end
      end
   end

   // Block until every queued beat is taken and every result is back.
   task automatic drain_all();
      while (pending_beats.size() != 0 || req_valid || rgb_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SOURCE_WIDTH) img_w = dim_of(value, MAX_WIDTH);
      else img_h = dim_of(value, MAX_HEIGHT);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_write(input int addr, input logic [PIXEL_BITS-1:0] rgb);
      remap_req_type item;
      item.operation     = OP_WRITE;
      item.pixel_address = ADDR_BITS'(addr);
      {item.wr_r, item.wr_g, item.wr_b} = rgb;
      item.u             = COORD_BITS'($urandom);
      item.v             = COORD_BITS'($urandom);
      item.frame_end     = 1'($urandom_range(0, 1));
      pending_beats.push_back(item);
   endtask

   task automatic push_sample(input int u, input int v, input logic last);
      remap_req_type item;
      item.operation     = OP_SAMPLE;
      item.pixel_address = ADDR_BITS'($urandom);
      item.wr_r          = CHAN_BITS'($urandom);
      item.wr_g          = CHAN_BITS'($urandom);
      item.wr_b          = CHAN_BITS'($urandom);
      item.u             = COORD_BITS'(u);
      item.v             = COORD_BITS'(v);
      item.frame_end     = last;
      pending_beats.push_back(item);
   endtask

   // One coordinate along an axis of n pixels: mostly near the image,
   // sometimes anywhere in the field, sometimes exactly half a pixel.
   function automatic int pick_coord(input int n);
      int c;
      if ($urandom_range(0, 9) == 0) return int'($urandom) % (1 << COORD_BITS);
      c = int'($urandom_range(0, (n - 1) * 256 + 600)) - 300;
      if ($urandom_range(0, 7) == 0) c = (c & ~255) | 128;
      return c;
   endfunction

   // Load a full image at the given register values, then stream samples.
   task automatic run_phase(input logic [DIM_BITS-1:0] w_val,
                            input logic [DIM_BITS-1:0] h_val, input int n_samples);
      int pix;
      drain_all();
      write_csr(REG_SOURCE_WIDTH, w_val);
      write_csr(REG_SOURCE_HEIGHT, h_val);
      for (pix = 0; pix < img_w * img_h; pix++) begin
         push_write(pix, PIXEL_BITS'($urandom));
         if ($urandom_range(0, 31) == 0) push_write($urandom_range(0, STORE_DEPTH - 1),
                                                    PIXEL_BITS'($urandom));
      end
      for (pix = 0; pix < n_samples; pix++) begin
         // occasionally repaint a pixel in place, or scribble from the last pixel onward
         if ($urandom_range(0, 11) == 0)
            push_write($urandom_range(0, img_w * img_h - 1), PIXEL_BITS'($urandom));
         if ($urandom_range(0, 23) == 0)
            push_write($urandom_range(img_w * img_h - 1, STORE_DEPTH - 1),
                       PIXEL_BITS'($urandom));
         push_sample(pick_coord(img_w), pick_coord(img_h), $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      int k;
      mismatches    = 0;
      quiet         = 1'b0;
      long_hold_req = 1'b0;
      gap_left      = 0;
      stall_left    = 0;
      hold_left     = 0;
      idle_cycles   = 0;
      img_w         = MAX_WIDTH;
      img_h         = MAX_HEIGHT;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_WRITE;
      req_pixel_address = '0;
      req_write_red     = '0;
      req_write_green   = '0;
      req_write_blue    = '0;
      req_sample_u      = '0;
      req_sample_v      = '0;
      req_frame_end     = 1'b0;
      rsp_stall         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = REG_SOURCE_WIDTH;
      csr_data          = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: 4 x 3 image with extreme channel values, edge coordinates.
      write_csr(REG_SOURCE_WIDTH, 10'd4);
      write_csr(REG_SOURCE_HEIGHT, 10'd3);
      for (k = 0; k < 12; k++)
         push_write(k, (k % 2 == 0) ? 24'hFFFFFF : 24'h000000);
      push_write(STORE_DEPTH - 1, 24'hA5A5A5);
      push_write(STORE_DEPTH / 2, 24'h5A5A5A);
      push_sample(-524288, -524288, 1'b0);
      push_sample(524287, 524287, 1'b1);
      push_sample(0, 0, 1'b0);
      push_sample(3 * 256, 2 * 256, 1'b0);
      push_sample(128, 0, 1'b0);
      push_sample(128, 128, 1'b1);
      push_sample(3 * 256 + 1, 2 * 256 + 1, 1'b0);
      push_sample(255, 255, 1'b0);
      push_sample(-1, 300, 1'b1);

      // Random phases across the geometry space, extremes included.
      run_phase(10'd0, 10'd0, 40);
      run_phase(10'd1, 10'd1, 40);
      // hold off the receiver while the previous phase's beats still drain
      long_hold_req = 1'b1;
      run_phase(10'd1023, 10'd1, 60);
      run_phase(10'd1, 10'd1023, 60);
      for (k = 0; k < 3; k++)
         run_phase(DIM_BITS'($urandom_range(2, 20)), DIM_BITS'($urandom_range(2, 20)), 80);

      // Closing stretch: no gaps and no stalls.
      drain_all();
      quiet = 1'b1;
      run_phase(DIM_BITS'($urandom_range(2, 16)), DIM_BITS'($urandom_range(2, 16)), 150);
      drain_all();

      if (mismatches == 0) begin
         $display("lut_bilinear_rgb_remap_unit regression: pass");
      end else begin
         $display("lut_bilinear_rgb_remap_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lbrr_pkg.sv
rtl/core/lbrr_ram.sv
rtl/core/lbrr_lerp.sv
rtl/core/lut_bilinear_rgb_remap_unit.sv
dv/tb_lut_bilinear_rgb_remap_unit.sv
